// ===== rtl/rnta_pkg.sv =====
// shared types, codes and helpers for the radix number to ascii unit
package rnta_pkg;

	localparam int MagW    = 64;
	localparam int DigRegW = 80;
	localparam int BcdDigits = DigRegW / 4;
	localparam int CntW    = 7;
	localparam int ConvCntW = 6;

	// radix codes on the opcode field
	localparam logic [2:0] OpDec   = 3'd0;
	localparam logic [2:0] OpHexLo = 3'd1;
	localparam logic [2:0] OpHexUp = 3'd2;
	localparam logic [2:0] OpOct   = 3'd3;
	localparam logic [2:0] OpBin   = 3'd4;

	localparam logic [6:0] CharZero     = 7'h30;
	localparam logic [6:0] CharDash     = 7'h2d;
	localparam logic [6:0] CharLowX     = 7'h78;
	localparam logic [6:0] CharUpX      = 7'h58;
	localparam logic [6:0] CharO        = 7'h6f;
	localparam logic [6:0] CharB        = 7'h62;
	localparam logic [6:0] LetterOffset = 7'd23;
	localparam logic [6:0] DecBase      = 7'd10;

	typedef struct packed {
		logic signed [MagW-1:0] value;
		logic [2:0]             opcode;
	} num_t;

	typedef struct packed {
		logic [6:0] text_char;
		logic       last;
		logic       error;
	} txt_t;

	typedef enum logic [1:0] {
		RAD_DEC,
		RAD_HEX,
		RAD_OCT,
		RAD_BIN
	} rad_t;

	typedef enum logic [2:0] {
		DR_HOLD,
		DR_LOAD_DEC,
		DR_LOAD_RAW,
		DR_DABBLE,
		DR_SHIFT
	} dr_op_t;

	typedef struct packed {
		dr_op_t op;
		rad_t   rad;
	} dr_ctrl_t;

	// ascii for one digit, letters follow the case of the prefix
	function automatic logic [6:0] digit_char(input logic [3:0] d, input logic upper);
		logic [6:0] base;
		base = (upper ? CharUpX : CharLowX) - LetterOffset;
		if ({3'b000, d} < DecBase)
			return CharZero + {3'b000, d};
		return ({3'b000, d} - DecBase) + base;
	endfunction

	// digit positions held in the digit register per radix
	function automatic logic [CntW-1:0] digit_count(input rad_t r);
		logic [CntW-1:0] n;
		unique case (r)
			RAD_DEC: n = CntW'(BcdDigits);
			RAD_HEX: n = CntW'(MagW / 4);
			RAD_OCT: n = CntW'((MagW + 2) / 3);
			RAD_BIN: n = CntW'(MagW);
			default: n = CntW'(MagW);
		endcase
		return n;
	endfunction

endpackage

// ===== rtl/rnta_digit_reg.sv =====
// digit shift register with bit-serial binary to bcd conversion
module rnta_digit_reg (
	input  logic                          clk,
	input  rnta_pkg::dr_ctrl_t            ctrl,
	input  logic signed [rnta_pkg::MagW-1:0] value,
	output logic [3:0]                    top_digit
);

	logic [rnta_pkg::DigRegW-1:0] digs_q;
	logic [rnta_pkg::MagW-1:0]    mag_q;
	logic [rnta_pkg::DigRegW-1:0] adj;
	logic [rnta_pkg::DigRegW-1:0] raw_load;

	// add-3 correction on every bcd digit before the next shift
	always_comb begin
		for (int i = 0; i < rnta_pkg::BcdDigits; i++) begin
			if (digs_q[i*4 +: 4] >= 4'd5)
				adj[i*4 +: 4] = digs_q[i*4 +: 4] + 4'd3;
			else
				adj[i*4 +: 4] = digs_q[i*4 +: 4];
		end
	end

	// left aligned so the most significant digit sits at the top
	always_comb begin
		if (ctrl.rad == rnta_pkg::RAD_OCT)
			raw_load = {2'b00, value, 14'b0};
		else
			raw_load = {value, 16'b0};
	end

	always_ff @(posedge clk) begin
		unique case (ctrl.op)
			rnta_pkg::DR_LOAD_DEC: begin
				digs_q <= '0;
				mag_q  <= value[rnta_pkg::MagW-1] ? (~value + 64'd1) : value;
			end
			rnta_pkg::DR_LOAD_RAW: begin
				digs_q <= raw_load;
			end
			rnta_pkg::DR_DABBLE: begin
				digs_q <= {adj[rnta_pkg::DigRegW-2:0], mag_q[rnta_pkg::MagW-1]};
				mag_q  <= {mag_q[rnta_pkg::MagW-2:0], 1'b0};
			end
			rnta_pkg::DR_SHIFT: begin
				unique case (ctrl.rad)
					rnta_pkg::RAD_OCT: digs_q <= {digs_q[rnta_pkg::DigRegW-4:0], 3'b000};
					rnta_pkg::RAD_BIN: digs_q <= {digs_q[rnta_pkg::DigRegW-2:0], 1'b0};
					default:           digs_q <= {digs_q[rnta_pkg::DigRegW-5:0], 4'b0000};
				endcase
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		unique case (ctrl.rad)
			rnta_pkg::RAD_OCT: top_digit = {1'b0, digs_q[rnta_pkg::DigRegW-1 -: 3]};
			rnta_pkg::RAD_BIN: top_digit = {3'b000, digs_q[rnta_pkg::DigRegW-1]};
			default:           top_digit = digs_q[rnta_pkg::DigRegW-1 -: 4];
		endcase
	end

endmodule

// ===== rtl/radix_number_to_ascii_unit.sv =====
// top level: sequencer, prefix generation and output register
//
// one number is taken on the num channel (value, opcode) and its text leaves on
// the txt channel one ascii character per transfer, most significant first, with
// last set on the final character. opcode 0 is decimal with a leading '-' for
// negatives, 1 and 2 are hex with prefix "0x" / "0X", 3 octal with 'o', 4 binary
// with 'b'. an unknown opcode or a negative value in a non-decimal radix gives a
// single transfer with error = 1, last = 1 and text_char = 0.
// a number is taken only while the unit is idle; num_stall is high from the cycle
// after a transfer until the last character has been written to the output
// register. after the prefix the digit register shifts once per cycle, without
// txt stalls, over all 16, 22 or 64 digit positions, dropping leading zeros,
// then switches to emitting. decimal first runs a bit-serial binary to bcd loop
// over all 64 magnitude bits, then the same walk over 20 bcd digits. the first
// character (prefix, '-' or error transfer) is registered once the output
// register is free; a non-negative decimal first converts and skips zeros. a
// stalled txt channel holds its character and holds back the next one;
// conversion and zero skipping go on.
// a new number is taken while the final character waits in the output register.
// reset returns the sequencer to idle and empties the output register.
module radix_number_to_ascii_unit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             num_valid,
	output logic             num_stall,
	input  rnta_pkg::num_t   num,
	output logic             txt_valid,
	input  logic             txt_stall,
	output rnta_pkg::txt_t   txt
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ERR,
		ST_PFX0,
		ST_PFX1,
		ST_CONV,
		ST_SKIP,
		ST_EMIT
	} st_t;

	st_t                              state_q, state_d;
	rnta_pkg::rad_t                   rad_q, rad_dec;
	logic                             upper_q, upper_dec;
	logic                             neg_q;
	logic [rnta_pkg::CntW-1:0]        rem_q;
	logic [rnta_pkg::ConvCntW-1:0]    conv_cnt_q;
	logic                             bad_code;
	logic                             accept;
	logic                             out_free;
	logic                             produce;
	rnta_pkg::txt_t                   prod_item;
	rnta_pkg::dr_ctrl_t               dr_ctrl;
	logic [3:0]                       top_digit;
	logic                             out_valid_q;
	rnta_pkg::txt_t                   out_q;

	assign num_stall = (state_q != ST_IDLE);
	assign accept    = num_valid && !num_stall;
	assign out_free  = !out_valid_q || !txt_stall;
	assign txt_valid = out_valid_q;
	assign txt       = out_q;

	// radix decode of the incoming opcode
	always_comb begin
		bad_code  = 1'b0;
		upper_dec = 1'b0;
		unique case (num.opcode)
			rnta_pkg::OpDec:   rad_dec = rnta_pkg::RAD_DEC;
			rnta_pkg::OpHexLo: rad_dec = rnta_pkg::RAD_HEX;
			rnta_pkg::OpHexUp: begin
				rad_dec   = rnta_pkg::RAD_HEX;
				upper_dec = 1'b1;
			end
			rnta_pkg::OpOct:   rad_dec = rnta_pkg::RAD_OCT;
			rnta_pkg::OpBin:   rad_dec = rnta_pkg::RAD_BIN;
			default: begin
				rad_dec  = rnta_pkg::RAD_DEC;
				bad_code = 1'b1;
			end
		endcase
	end

	// sequencer: next state, digit register command, produced character
	always_comb begin
		state_d        = state_q;
		produce        = 1'b0;
		prod_item      = '0;
		dr_ctrl.op     = rnta_pkg::DR_HOLD;
		dr_ctrl.rad    = rad_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					dr_ctrl.rad = rad_dec;
					dr_ctrl.op  = (rad_dec == rnta_pkg::RAD_DEC) ?
						rnta_pkg::DR_LOAD_DEC : rnta_pkg::DR_LOAD_RAW;
					if (bad_code || (num.value[rnta_pkg::MagW-1] &&
						rad_dec != rnta_pkg::RAD_DEC))
						state_d = ST_ERR;
					else if (rad_dec == rnta_pkg::RAD_DEC && !num.value[rnta_pkg::MagW-1])
						state_d = ST_CONV;
					else
						state_d = ST_PFX0;
				end
			end
			ST_ERR: begin
				if (out_free) begin
					produce         = 1'b1;
					prod_item.last  = 1'b1;
					prod_item.error = 1'b1;
					state_d         = ST_IDLE;
				end
			end
			ST_PFX0: begin
				if (out_free) begin
					produce = 1'b1;
					unique case (rad_q)
						rnta_pkg::RAD_DEC: begin
							prod_item.text_char = rnta_pkg::CharDash;
							state_d             = ST_CONV;
						end
						rnta_pkg::RAD_HEX: begin
							prod_item.text_char = rnta_pkg::CharZero;
							state_d             = ST_PFX1;
						end
						rnta_pkg::RAD_OCT: begin
							prod_item.text_char = rnta_pkg::CharO;
							state_d             = ST_SKIP;
						end
						default: begin
							prod_item.text_char = rnta_pkg::CharB;
							state_d             = ST_SKIP;
						end
					endcase
				end
			end
			ST_PFX1: begin
				if (out_free) begin
					produce             = 1'b1;
					prod_item.text_char = upper_q ? rnta_pkg::CharUpX : rnta_pkg::CharLowX;
					state_d             = ST_SKIP;
				end
			end
			ST_CONV: begin
				dr_ctrl.op = rnta_pkg::DR_DABBLE;
				if (conv_cnt_q == '1)
					state_d = ST_SKIP;
			end
			ST_SKIP: begin
				// drop leading zero digits, always keep the last one
				if (top_digit == 4'd0 && rem_q > rnta_pkg::CntW'(1))
					dr_ctrl.op = rnta_pkg::DR_SHIFT;
				else
					state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (out_free) begin
					produce             = 1'b1;
					dr_ctrl.op          = rnta_pkg::DR_SHIFT;
					prod_item.text_char = rnta_pkg::digit_char(top_digit, upper_q);
					prod_item.last      = (rem_q == rnta_pkg::CntW'(1));
					if (rem_q == rnta_pkg::CntW'(1))
						state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
			conv_cnt_q  <= '0;
			rem_q       <= '0;
		end else begin
			state_q <= state_d;
			if (produce) begin
				out_valid_q <= 1'b1;
				out_q       <= prod_item;
			end else if (!txt_stall) begin
				out_valid_q <= 1'b0;
			end
			if (accept) begin
				rad_q      <= rad_dec;
				upper_q    <= upper_dec;
				neg_q      <= num.value[rnta_pkg::MagW-1];
				conv_cnt_q <= '0;
				rem_q      <= rnta_pkg::digit_count(rad_dec);
			end else begin
				if (state_q == ST_CONV)
					conv_cnt_q <= conv_cnt_q + rnta_pkg::ConvCntW'(1);
				if (dr_ctrl.op == rnta_pkg::DR_SHIFT)
					rem_q <= rem_q - rnta_pkg::CntW'(1);
			end
		end
	end

	rnta_digit_reg u_digit_reg (
		.clk       (clk),
		.ctrl      (dr_ctrl),
		.value     (num.value),
		.top_digit (top_digit)
	);

	// a decimal prefix only ever appears for a negative number
	a_dash_neg: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_PFX0 && rad_q == rnta_pkg::RAD_DEC) |-> neg_q)
		else $error("minus prefix on a non-negative number");

	a_err_form: assert property (@(posedge clk) disable iff (!arst_n)
		(txt_valid && txt.error) |-> (txt.last && txt.text_char == 7'd0))
		else $error("malformed error transfer");

	a_char_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(txt_valid && !txt.error) |-> (txt.text_char != 7'd0))
		else $error("null character on a text transfer");

	a_rem_live: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT || state_q == ST_SKIP) |-> (rem_q != '0))
		else $error("digit count ran out while emitting");

	a_take_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> num_stall)
		else $error("second number taken while busy");

endmodule

// ===== tb/radix_text_checker.sv =====
// checker for the radix number to ascii unit: predicts the text of each number and compares
`timescale 1ns / 100ps

module radix_text_checker (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             num_valid,
	input  logic             num_stall,
	input  rnta_pkg::num_t   num,
	input  logic             txt_valid,
	input  logic             txt_stall,
	input  rnta_pkg::txt_t   txt,
	output int               mismatch_count,
	output int               awaiting
);

	localparam logic [6:0] LetterLow = 7'h61;
	localparam logic [6:0] LetterUp  = 7'h41;
	localparam int         ShownMax  = 10;

	rnta_pkg::txt_t expected_text[$];
	int   fail_tally = 0;
	int   pending_chars = 0;

	assign mismatch_count = fail_tally;
	assign awaiting       = pending_chars;

	// characters of one number, most significant first, appended to expected_text
	function automatic void predict_text(input rnta_pkg::num_t item);
		logic           neg;
		logic [63:0]    mag;
		logic [63:0]    base;
		logic [63:0]    d;
		logic [6:0]     chars[$];
		rnta_pkg::txt_t exp_r;
		neg = item.value[63];
		case (item.opcode) inside
			rnta_pkg::OpDec:                    base = 64'd10;
			rnta_pkg::OpHexLo, rnta_pkg::OpHexUp: base = 64'd16;
			rnta_pkg::OpOct:                    base = 64'd8;
			rnta_pkg::OpBin:                    base = 64'd2;
			default:                            base = 64'd0;
		endcase
		if (base == 64'd0 || (neg && item.opcode != rnta_pkg::OpDec)) begin
			exp_r.text_char = 7'd0;
			exp_r.last      = 1'b1;
			exp_r.error     = 1'b1;
			expected_text.push_back(exp_r);
			return;
		end
		// magnitude in unsigned arithmetic, so the most negative value is safe
		mag = neg ? 64'd0 - item.value : item.value;
		do begin
			d = mag % base;
			if (d < 64'd10)
				chars.push_front(rnta_pkg::CharZero + 7'(d));
			else
				chars.push_front(((item.opcode == rnta_pkg::OpHexUp) ? LetterUp : LetterLow)
					+ 7'(d - 64'd10));
			mag = mag / base;
		end while (mag != 64'd0);
		case (item.opcode) inside
			rnta_pkg::OpDec: begin
				if (neg)
					chars.push_front(rnta_pkg::CharDash);
			end
			rnta_pkg::OpHexLo, rnta_pkg::OpHexUp: begin
				chars.push_front((item.opcode == rnta_pkg::OpHexUp) ?
					rnta_pkg::CharUpX : rnta_pkg::CharLowX);
				chars.push_front(rnta_pkg::CharZero);
			end
			rnta_pkg::OpOct: chars.push_front(rnta_pkg::CharO);
			default:         chars.push_front(rnta_pkg::CharB);
		endcase
		foreach (chars[i]) begin
			exp_r.text_char = chars[i];
			exp_r.last      = (i == chars.size() - 1);
			exp_r.error     = 1'b0;
			expected_text.push_back(exp_r);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		rnta_pkg::txt_t want;
		if (!arst_n) begin
			expected_text.delete();
			pending_chars = 0;
		end else begin
			// results first, so a number taken in this cycle cannot answer itself
			if (txt_valid && !txt_stall) begin
				if (expected_text.size() == 0) begin
					fail_tally++;
					if (fail_tally <= ShownMax)
						$display("%0t: txt transfer with nothing expected: char %h last %b error %b",
							$realtime, txt.text_char, txt.last, txt.error);
				end else begin
					want = expected_text.pop_front();
					if (txt.text_char !== want.text_char || txt.last !== want.last
							|| txt.error !== want.error) begin
						fail_tally++;
						if (fail_tally <= ShownMax)
							$display("%0t: txt mismatch: char %h/%h last %b/%b error %b/%b (exp/act)",
								$realtime, want.text_char, txt.text_char, want.last, txt.last,
								want.error, txt.error);
					end
				end
			end
			if (num_valid && !num_stall)
				predict_text(num);
			pending_chars = expected_text.size();
		end
	end

endmodule

// ===== tb/tb.sv =====
// testbench top for the radix number to ascii unit: reset, stimulus, stall pattern and verdict
`timescale 1ns / 100ps

module tb;

	// opcodes past binary are all invalid radix codes
	localparam logic [2:0] OpFirstBad = 3'd5;
	localparam logic [2:0] OpMidBad   = 3'd6;
	localparam logic [2:0] OpLastBad  = 3'd7;
	// far above the slowest legal run: 460 binary numbers of 64 chars, each char
	// held off by the longest txt stall, plus the longest sender gaps
	localparam int CycleLimit   = 10_000_000;
	localparam int RandomItems  = 435;
	localparam int DrainCycles  = 150;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             num_valid;
	logic             num_stall;
	rnta_pkg::num_t   num;
	logic             txt_valid;
	logic             txt_stall;
	rnta_pkg::txt_t   txt;
	int               mismatch_count;
	int               awaiting;
	int               cycles = 0;
	bit               sender_eager = 1'b0;

	always #5 clk = ~clk;

	radix_number_to_ascii_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.num_valid (num_valid),
		.num_stall (num_stall),
		.num       (num),
		.txt_valid (txt_valid),
		.txt_stall (txt_stall),
		.txt       (txt)
	);

	radix_text_checker checker_i (
		.clk            (clk),
		.arst_n         (arst_n),
		.num_valid      (num_valid),
		.num_stall      (num_stall),
		.num            (num),
		.txt_valid      (txt_valid),
		.txt_stall      (txt_stall),
		.txt            (txt),
		.mismatch_count (mismatch_count),
		.awaiting       (awaiting)
	);

	// length of an idle or stall stretch: mostly short, a few long
	function automatic int idle_span();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return $urandom_range(1, 3);
		if (r < 95)
			return $urandom_range(4, 12);
		return $urandom_range(25, 60);
	endfunction

	// values spread over the whole range, small ones, bit lengths, powers of two
	// and the extremes
	function automatic logic signed [63:0] rand_value();
		logic [63:0] v;
		case ($urandom_range(0, 9))
			0, 1, 2: v = {$urandom, $urandom};
			3, 4:    v = 64'($urandom_range(0, 999));
			5, 6:    v = {$urandom, $urandom} >> $urandom_range(1, 63);
			7:       v = (64'd1 << $urandom_range(0, 63)) - 64'($urandom_range(0, 1));
			8:       v = 64'h7fff_ffff_ffff_ffff - 64'($urandom_range(0, 3));
			default: v = 64'd0 - 64'($urandom_range(1, 1000));
		endcase
		return v;
	endfunction

	// one number on the num channel; called and returning at a falling edge
	task automatic push_number(input logic signed [63:0] v, input logic [2:0] op);
		int gap;
		gap = 0;
		if (!sender_eager && $urandom_range(0, 99) >= 45)
			gap = idle_span();
		if (gap > 0) begin
			num_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		num.value  <= v;
		num.opcode <= op;
		num_valid  <= 1'b1;
		// the unit takes the number at the first rising edge without stall
		do @(posedge clk); while (num_stall);
		@(negedge clk);
	endtask

	// sender holds off until every expected character has been seen
	task automatic drain_text();
		num_valid <= 1'b0;
		@(negedge clk);
		while (awaiting != 0)
			@(negedge clk);
	endtask

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CycleLimit) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// txt receiver stall pattern: free stretches, sometimes long ones with no
	// stall at all, then a stall burst
	initial begin
		txt_stall = 1'b0;
		wait (arst_n);
		@(negedge clk);
		forever begin
			txt_stall <= 1'b0;
			repeat (($urandom_range(0, 7) == 0) ? $urandom_range(60, 300) : $urandom_range(1, 8))
				@(negedge clk);
			txt_stall <= 1'b1;
			repeat (idle_span()) @(negedge clk);
		end
	end

	initial begin
		logic signed [63:0] v;
		logic [2:0]         op;
		int                 r;
		num_valid = 1'b0;
		num       = '0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// directed: zero in every radix, digit boundaries, the extremes
		push_number(64'sd0, rnta_pkg::OpDec);
		push_number(64'sd9, rnta_pkg::OpDec);
		push_number(64'sd10, rnta_pkg::OpDec);
		push_number(64'sh7fff_ffff_ffff_ffff, rnta_pkg::OpDec);
		// most negative value needs its magnitude without overflow
		push_number(64'sh8000_0000_0000_0000, rnta_pkg::OpDec);
		push_number(-64'sd1, rnta_pkg::OpDec);
		push_number(64'sd0, rnta_pkg::OpHexLo);
		// every hex letter, in both cases
		push_number(64'sh0123_4567_89ab_cdef, rnta_pkg::OpHexLo);
		push_number(64'sh7fff_ffff_ffff_ffff, rnta_pkg::OpHexLo);
		push_number(64'sd0, rnta_pkg::OpHexUp);
		push_number(64'sh0123_4567_89ab_cdef, rnta_pkg::OpHexUp);
		push_number(64'sd0, rnta_pkg::OpOct);
		push_number(64'sd7, rnta_pkg::OpOct);
		push_number(64'sd8, rnta_pkg::OpOct);
		push_number(64'sh7fff_ffff_ffff_ffff, rnta_pkg::OpOct);
		push_number(64'sd0, rnta_pkg::OpBin);
		push_number(64'sd1, rnta_pkg::OpBin);
		// longest text: 'b' and 63 digits
		push_number(64'sh7fff_ffff_ffff_ffff, rnta_pkg::OpBin);
		// negative value outside decimal is an error
		push_number(-64'sd1, rnta_pkg::OpHexLo);
		push_number(64'sh8000_0000_0000_0000, rnta_pkg::OpHexUp);
		push_number(-64'sd5, rnta_pkg::OpOct);
		push_number(-64'sd1, rnta_pkg::OpBin);
		// unknown radix codes
		push_number(64'sd0, OpFirstBad);
		push_number(64'sh7fff_ffff_ffff_ffff, OpMidBad);
		push_number(64'sh8000_0000_0000_0000, OpLastBad);

		drain_text();

		// random: mostly well-formed numbers, some errors and unknown codes
		for (int i = 0; i < RandomItems; i++) begin
			if (i % 40 == 0)
				sender_eager = ($urandom_range(0, 3) == 0);
			if (i == RandomItems / 2)
				drain_text();
			v = rand_value();
			r = $urandom_range(0, 19);
			if (r < 17) begin
				op = 3'($urandom_range(rnta_pkg::OpDec, rnta_pkg::OpBin));
				if (op != rnta_pkg::OpDec && r < 15)
					v[63] = 1'b0;
			end else if (r < 19) begin
				op = 3'($urandom_range(OpFirstBad, OpLastBad));
			end else begin
				op = 3'($urandom_range(rnta_pkg::OpHexLo, rnta_pkg::OpBin));
				v[63] = 1'b1;
			end
			push_number(v, op);
		end

		num_valid <= 1'b0;
		while (awaiting != 0)
			@(negedge clk);
		// stray characters after the last expected one still count
		repeat (DrainCycles) @(negedge clk);
		if (mismatch_count == 0 && awaiting == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
